// ===== sv/assert_macros.svh =====
// Assertion macros included by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define AST_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/stp_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// stp_pkg
// Types and constants of the stable topological sort unit.
// ============================================================================
package stp_pkg;

    localparam int FIELD_W = 16;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_AFTER  = 2'd1,
        REQ_BEFORE = 2'd2,
        REQ_GO     = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t            req_type;
        logic [FIELD_W-1:0]   node_id;
        logic [FIELD_W-1:0]   other_id;
    } req_t;

    typedef struct packed {
        logic [FIELD_W-1:0]   sorted_id;
        logic                 id_valid;
        logic                 last;
        logic                 cycle_found;
    } rsp_t;

endpackage

// ===== sv/stable_topological_sort.sv =====
// Load: ids are matched by a memory sweep over the loaded entries, then the new entry is written.
// Constraint: the same sweep over the loaded entries, then the successor row read and update.
// Go: each emitted node takes a pick, then a row read and counter update.
// One transaction is worked on at a time; the result register frees the output side.
// Reset (async, active low) empties the loaded set; memories hold no reset value.
`timescale 1ns / 1ps
// ============================================================================
// stable_topological_sort
// Kahn sort with load-order tie break; ids and successor rows in sync memories.
// ============================================================================
module stable_topological_sort #(
    parameter int MAX_NODES = 32,
    parameter int ID_BITS   = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  stp_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output stp_pkg::rsp_t rsp
);
    import stp_pkg::*;
    `include "assert_macros.svh"

    localparam int IW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int IDW = (ID_BITS < FIELD_W) ? ID_BITS : FIELD_W;
    localparam logic [CW-1:0] FULL = CW'(MAX_NODES);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SRD  = 8'b0000_0010,
        S_SCMP = 8'b0000_0100,
        S_LOAD = 8'b0000_1000,
        S_RRD  = 8'b0001_0000,
        S_RWR  = 8'b0010_0000,
        S_PICK = 8'b0100_0000,
        S_GRD  = 8'b1000_0000
    } state_t;

    state_t                 state_reg;
    req_type_t              type_reg;
    logic [IDW-1:0]         a_reg, b_reg;
    logic [CW-1:0]          cnt_reg;
    logic [IW-1:0]          idx_reg, ia_reg, ib_reg;
    logic                   fa_reg, fb_reg;
    logic [MAX_NODES-1:0]   emit_reg;
    logic [CW-1:0]          emitted_n_reg;
    logic                   hold_v_reg;
    logic [IDW-1:0]         hold_id_reg;
    logic [CW-1:0]          pend_reg [MAX_NODES];
    rsp_t                   out_reg;
    logic                   out_v_reg;
    logic                   out_v_next;

    logic [IDW-1:0]         id_mem  [MAX_NODES];
    logic [MAX_NODES-1:0]   row_mem [MAX_NODES];
    logic [IDW-1:0]         id_rd_reg;
    logic [MAX_NODES-1:0]   row_rd_reg;

    logic [IW-1:0]          from_idx, to_idx, rd_addr, pick;
    logic                   rd_en, any_ready, out_free, hit_a, hit_b, idx_last;
    logic                   row_we;
    logic [IW-1:0]          row_waddr;
    logic [MAX_NODES-1:0]   row_wdata;
    logic [MAX_NODES-1:0]   ready;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_v_reg;
    assign rsp       = out_reg;
    assign out_free  = !out_v_reg || !rsp_stall;

    assign from_idx = (type_reg == REQ_AFTER) ? ib_reg : ia_reg;
    assign to_idx   = (type_reg == REQ_AFTER) ? ia_reg : ib_reg;
    assign hit_a    = (id_rd_reg == a_reg);
    assign hit_b    = (id_rd_reg == b_reg);
    assign idx_last = ((CW'(idx_reg) + CW'(1)) == cnt_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_NODES; i++)
        begin
            ready[i] = (CW'(i) < cnt_reg) && !emit_reg[i] && (pend_reg[i] == '0);
        end
        pick      = '0;
        any_ready = 1'b0;
        for (int i = MAX_NODES - 1; i >= 0; i--)
        begin
            if (ready[i])
            begin
                pick      = IW'(i);
                any_ready = 1'b1;
            end
        end
    end

    always_comb
    begin
        rd_en = 1'b1;
        case (state_reg)
            S_SRD:   rd_addr = idx_reg;
            S_RRD:   rd_addr = from_idx;
            S_PICK:  rd_addr = pick;
            default:
            begin
                rd_addr = idx_reg;
                rd_en   = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        row_we    = 1'b0;
        row_waddr = cnt_reg[IW-1:0];
        row_wdata = '0;
        if (state_reg == S_LOAD)
        begin
            row_we = 1'b1;
        end
        else if (state_reg == S_RWR && !row_rd_reg[to_idx])
        begin
            row_we    = 1'b1;
            row_waddr = from_idx;
            row_wdata = row_rd_reg | (MAX_NODES'(1) << to_idx);
        end
    end

    always_comb
    begin
        out_v_next = out_v_reg && rsp_stall;
        if (state_reg == S_PICK && !any_ready && out_free)
            out_v_next = 1'b1;
        else if (state_reg == S_GRD && hold_v_reg && out_free)
            out_v_next = 1'b1;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            id_mem[cnt_reg[IW-1:0]] <= a_reg;
        end
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (rd_en)
        begin
            id_rd_reg  <= id_mem[rd_addr];
            row_rd_reg <= row_mem[rd_addr];
        end
    end

    // predecessor counters
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            pend_reg[cnt_reg[IW-1:0]] <= '0;
        end
        else if (state_reg == S_RWR && !row_rd_reg[to_idx])
        begin
            pend_reg[to_idx] <= pend_reg[to_idx] + CW'(1);
        end
        else if (state_reg == S_GRD && (!hold_v_reg || out_free))
        begin
            for (int j = 0; j < MAX_NODES; j++)
            begin
                if (row_rd_reg[j] && pend_reg[j] != '0)
                begin
                    pend_reg[j] <= pend_reg[j] - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_v_reg     <= 1'b0;
            hold_v_reg    <= 1'b0;
            emit_reg      <= '0;
            emitted_n_reg <= '0;
            fa_reg        <= 1'b0;
            fb_reg        <= 1'b0;
            idx_reg       <= '0;
            ia_reg        <= '0;
            ib_reg        <= '0;
            type_reg      <= REQ_LOAD;
            a_reg         <= '0;
            b_reg         <= '0;
            hold_id_reg   <= '0;
            out_reg       <= '0;
        end
        else
        begin
            out_v_reg <= out_v_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        type_reg <= req.req_type;
                        a_reg    <= req.node_id[IDW-1:0];
                        b_reg    <= req.other_id[IDW-1:0];
                        fa_reg   <= 1'b0;
                        fb_reg   <= 1'b0;
                        idx_reg  <= '0;
                        case (req.req_type)
                            REQ_LOAD:
                            begin
                                if (cnt_reg == FULL)
                                    state_reg <= S_IDLE;
                                else if (cnt_reg == '0)
                                    state_reg <= S_LOAD;
                                else
                                    state_reg <= S_SRD;
                            end
                            REQ_GO:
                            begin
                                emit_reg      <= '0;
                                emitted_n_reg <= '0;
                                hold_v_reg    <= 1'b0;
                                state_reg     <= S_PICK;
                            end
                            default:
                            begin
                                state_reg <= (cnt_reg == '0) ? S_IDLE : S_SRD;
                            end
                        endcase
                    end
                end
                S_SRD:
                begin
                    state_reg <= S_SCMP;
                end
                S_SCMP:
                begin
                    if (hit_a)
                    begin
                        fa_reg <= 1'b1;
                        ia_reg <= idx_reg;
                    end
                    if (hit_b)
                    begin
                        fb_reg <= 1'b1;
                        ib_reg <= idx_reg;
                    end
                    if (!idx_last)
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= S_SRD;
                    end
                    else if (type_reg == REQ_LOAD)
                    begin
                        state_reg <= (fa_reg || hit_a) ? S_IDLE : S_LOAD;
                    end
                    else
                    begin
                        state_reg <= ((fa_reg || hit_a) && (fb_reg || hit_b)) ? S_RRD : S_IDLE;
                    end
                end
                S_LOAD:
                begin
                    cnt_reg   <= cnt_reg + CW'(1);
                    state_reg <= S_IDLE;
                end
                S_RRD:
                begin
                    state_reg <= S_RWR;
                end
                S_RWR:
                begin
                    state_reg <= S_IDLE;
                end
                S_PICK:
                begin
                    if (any_ready)
                    begin
                        emit_reg[pick] <= 1'b1;
                        emitted_n_reg  <= emitted_n_reg + CW'(1);
                        state_reg      <= S_GRD;
                    end
                    else if (out_free)
                    begin
                        if (hold_v_reg)
                        begin
                            out_reg <= '{sorted_id: FIELD_W'(hold_id_reg), id_valid: 1'b1,
                                         last: 1'b1, cycle_found: (emitted_n_reg < cnt_reg)};
                        end
                        else
                        begin
                            out_reg <= '{sorted_id: '0, id_valid: 1'b0,
                                         last: 1'b1, cycle_found: 1'b1};
                        end
                        hold_v_reg <= 1'b0;
                        cnt_reg    <= '0;
                        state_reg  <= S_IDLE;
                    end
                end
                S_GRD:
                begin
                    if (!hold_v_reg || out_free)
                    begin
                        if (hold_v_reg)
                        begin
                            out_reg   <= '{sorted_id: FIELD_W'(hold_id_reg), id_valid: 1'b1,
                                           last: 1'b0, cycle_found: 1'b0};
                        end
                        hold_id_reg <= id_rd_reg;
                        hold_v_reg  <= 1'b1;
                        state_reg   <= S_PICK;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `AST_IMPLY(a_cnt_bound, 1'b1, cnt_reg <= FULL)
    `AST_IMPLY(a_emit_bound, state_reg == S_PICK, emitted_n_reg <= cnt_reg)
    `AST_IMPLY(a_null_last, rsp_valid && !rsp.id_valid, rsp.last && rsp.cycle_found)
    `AST_NEXT(a_grd_next, state_reg == S_GRD, state_reg == S_PICK || state_reg == S_GRD)

endmodule

// ===== bench/stable_topological_sort_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// stable_topological_sort_checker
// Watches both channels of the sort unit, keeps its own loaded set and
// dependency graph, works out the order each go transaction must produce and
// compares every result transaction with the oldest expected one.
// ============================================================================
module stable_topological_sort_checker #(
    parameter int MAX_NODES = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  stp_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  stp_pkg::rsp_t rsp,
    output int            fail_count,
    output int            pending_count,
    output int            sorted_total,
    output int            cycle_total
);
    import stp_pkg::*;

    logic [15:0]          loaded_ids [MAX_NODES];
    int                   loaded_n;
    logic [MAX_NODES-1:0] succ_rows [MAX_NODES];
    int                   preds_left [MAX_NODES];
    rsp_t                 order_q [$];

    function automatic int lookup_node(logic [15:0] id);
        for (int i = 0; i < loaded_n; i++)
            if (loaded_ids[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void link_nodes(int from, int to);
        if (!succ_rows[from][to])
        begin
            succ_rows[from][to] = 1'b1;
            preds_left[to]++;
        end
    endfunction

    function automatic void sort_loaded();
        logic [MAX_NODES-1:0] done_mask;
        int                   pick;
        int                   emitted;
        rsp_t                 r;
        done_mask = '0;
        emitted = 0;
        forever
        begin
            pick = -1;
            for (int i = 0; i < loaded_n; i++)
                if (!done_mask[i] && preds_left[i] == 0)
                begin
                    pick = i;
                    break;
                end
            if (pick < 0)
                break;
            done_mask[pick] = 1'b1;
            r = '{sorted_id: loaded_ids[pick], id_valid: 1'b1, last: 1'b0,
                  cycle_found: 1'b0};
            order_q = {order_q, r};
            emitted++;
            for (int j = 0; j < loaded_n; j++)
                if (succ_rows[pick][j] && preds_left[j] > 0)
                    preds_left[j]--;
        end
        if (emitted == 0)
        begin
            r = '{sorted_id: '0, id_valid: 1'b0, last: 1'b1, cycle_found: 1'b1};
            order_q = {order_q, r};
        end
        else
        begin
            r = order_q.pop_back();
            r.last = 1'b1;
            r.cycle_found = (emitted < loaded_n);
            order_q = {order_q, r};
        end
        loaded_n = 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_rsp;
        int   ia;
        int   ib;
        if (!rst_n)
        begin
            loaded_n = 0;
            fail_count <= 0;
            sorted_total <= 0;
            cycle_total <= 0;
            order_q.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (order_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("%0t: unexpected result %h", $realtime, rsp);
                end
                else
                begin
                    exp_rsp = order_q.pop_front();
                    if (rsp.id_valid) sorted_total <= sorted_total + 1;
                    if (rsp.cycle_found) cycle_total <= cycle_total + 1;
                    if (rsp.sorted_id !== exp_rsp.sorted_id
                        || rsp.id_valid !== exp_rsp.id_valid
                        || rsp.last !== exp_rsp.last
                        || rsp.cycle_found !== exp_rsp.cycle_found)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("%0t: mismatch id %h/%h valid %b/%b last %b/%b cyc %b/%b",
                                $realtime, exp_rsp.sorted_id, rsp.sorted_id,
                                exp_rsp.id_valid, rsp.id_valid, exp_rsp.last, rsp.last,
                                exp_rsp.cycle_found, rsp.cycle_found);
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                case (req.req_type)
                    REQ_LOAD:
                        if (loaded_n < MAX_NODES && lookup_node(req.node_id) < 0)
                        begin
                            loaded_ids[loaded_n] = req.node_id;
                            succ_rows[loaded_n] = '0;
                            preds_left[loaded_n] = 0;
                            loaded_n++;
                        end
                    REQ_AFTER, REQ_BEFORE:
                    begin
                        ia = lookup_node(req.node_id);
                        ib = lookup_node(req.other_id);
                        if (ia >= 0 && ib >= 0)
                        begin
                            if (req.req_type == REQ_AFTER)
                                link_nodes(ib, ia);
                            else
                                link_nodes(ia, ib);
                        end
                    end
                    default:
                        sort_loaded();
                endcase
            end
        end
    end

    assign pending_count = order_q.size();

endmodule

// ===== bench/stable_topological_sort_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// stable_topological_sort_tb
// Feeds node loads, ordering constraints and go transactions to the sort
// unit with random idle and stall bursts and one long output hold-off;
// the checker predicts and compares every result transaction.
// ============================================================================
module stable_topological_sort_tb;
    import stp_pkg::*;

    localparam int MAX_NODES   = 32;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    int   fail_count;
    int   pending_count;
    int   sorted_total;
    int   cycle_total;
    int   cycle_cnt;
    int   sent_total;
    bit   quiet_phase;
    bit   hold_off;

    stable_topological_sort #(.MAX_NODES(MAX_NODES), .ID_BITS(16)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    stable_topological_sort_checker #(.MAX_NODES(MAX_NODES)) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .sorted_total  (sorted_total),
        .cycle_total   (cycle_total)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // output stall: random bursts, one long hold-off, none at the end
    initial
    begin
        int n;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                rsp_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
                rsp_stall <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 7);
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    task automatic send_req(req_type_t t, logic [15:0] a, logic [15:0] b);
        int n;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            n = $urandom_range(1, 7);
            repeat (n) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= '{req_type: t, node_id: a, other_id: b};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent_total++;
    endtask

    task automatic drain_results();
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // one well-formed batch: loads, random constraints, go
    task automatic sort_batch(int nodes, int edges);
        logic [15:0] ids [$];
        logic [15:0] id;
        int          k;
        for (k = 0; k < nodes; k++)
        begin
            id = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 40)) : 16'($urandom);
            ids = {ids, id};
            send_req(REQ_LOAD, id, 16'($urandom));
        end
        for (k = 0; k < edges; k++)
        begin
            if (ids.size() == 0 || $urandom_range(0, 9) == 0)
                send_req(req_type_t'($urandom_range(1, 2)), 16'($urandom), 16'($urandom));
            else
                send_req(req_type_t'($urandom_range(1, 2)),
                         ids[$urandom_range(0, ids.size() - 1)],
                         ids[$urandom_range(0, ids.size() - 1)]);
        end
        send_req(REQ_GO, 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        cycle_cnt = 0;
        sent_total = 0;
        quiet_phase = 1'b0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty set
        send_req(REQ_GO, 16'h0000, 16'h0000);
        // extremes, duplicate load, unknown ids, repeated edge, one node ahead of two
        send_req(REQ_LOAD, 16'hFFFF, 16'h0000);
        send_req(REQ_LOAD, 16'h0000, 16'hFFFF);
        send_req(REQ_LOAD, 16'hFFFF, 16'h0000);
        send_req(REQ_LOAD, 16'h5555, 16'hAAAA);
        send_req(REQ_AFTER, 16'hFFFF, 16'h5555);
        send_req(REQ_AFTER, 16'hFFFF, 16'h5555);
        send_req(REQ_BEFORE, 16'h5555, 16'h0000);
        send_req(REQ_AFTER, 16'h1234, 16'h0000);
        send_req(REQ_BEFORE, 16'h0000, 16'hAAAA);
        send_req(REQ_GO, 16'hAAAA, 16'h5555);
        // self constraint
        send_req(REQ_LOAD, 16'h0001, 16'h0000);
        send_req(REQ_LOAD, 16'h0002, 16'h0000);
        send_req(REQ_AFTER, 16'h0002, 16'h0002);
        send_req(REQ_GO, 16'h0000, 16'h0000);
        // full cycle: nothing emitted
        send_req(REQ_LOAD, 16'h0010, 16'h0000);
        send_req(REQ_LOAD, 16'h0020, 16'h0000);
        send_req(REQ_BEFORE, 16'h0010, 16'h0020);
        send_req(REQ_BEFORE, 16'h0020, 16'h0010);
        send_req(REQ_GO, 16'h0000, 16'h0000);
        // full table plus one ignored load; later requests wait behind the hold-off
        for (int k = 0; k <= MAX_NODES; k++)
            send_req(REQ_LOAD, 16'(16'h0100 + k), 16'h0000);
        send_req(REQ_BEFORE, 16'h0100, 16'(16'h0100 + MAX_NODES - 1));
        hold_off = 1'b1;
        send_req(REQ_GO, 16'h0000, 16'h0000);

        while (sent_total < 120)
        begin
            if (sent_total > 95)
                quiet_phase = 1'b1;
            if ($urandom_range(0, 7) == 0)
                send_req(req_type_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
            else
                sort_batch($urandom_range(0, 6), $urandom_range(0, 8));
        end
        send_req(REQ_GO, 16'h0000, 16'h0000);
        req_valid <= 1'b0;
        drain_results();
        repeat (100) @(posedge clk);

        $display("Covered %0d request transactions, %0d sorted ids, %0d cycle reports.",
            sent_total, sorted_total, cycle_total);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
